// File: src/grm_pkg.sv
// ----------------------------------------------------------------------------
// grm_pkg
// Shared types and register codes of the 2x2x2 mean restriction block.
// ----------------------------------------------------------------------------
package grm_pkg;

  localparam int CFG_DATA_W  = 8;
  localparam int CFG_INDEX_W = 2;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_FINE_WIDTH  = 2'd0,
    CFG_FINE_HEIGHT = 2'd1,
    CFG_FINE_DEPTH  = 2'd2
  } cfg_reg_t;

  localparam logic [CFG_DATA_W-1:0] EXTENT_RESET = 8'd128;
  localparam logic [CFG_DATA_W-1:0] EXTENT_MIN   = 8'd2;

  typedef struct packed {
    logic first;
    logic emit;
    logic last_cell;
  } item_ctl_t;

endpackage

// File: src/grm_acc.sv
// ----------------------------------------------------------------------------
// grm_acc
// Accumulator memory with read-modify-write and write forwarding.
// ----------------------------------------------------------------------------
module grm_acc
  import grm_pkg::*;
#(
  parameter int VALUE_WIDTH = 32,
  parameter int DEPTH       = 4096,
  parameter int ADDR_W      = 12
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  input  logic [ADDR_W-1:0]             req_addr,
  input  logic signed [VALUE_WIDTH-1:0] req_value,
  input  item_ctl_t                     req_ctl,
  output logic                          res_valid,
  output logic signed [VALUE_WIDTH-1:0] res_value,
  output logic                          res_last
);

  localparam int SUM_W = VALUE_WIDTH + 3;

  logic signed [SUM_W-1:0]       mem [DEPTH];
  logic signed [SUM_W-1:0]       rd_data;

  logic                          s1_valid;
  logic [ADDR_W-1:0]             s1_addr;
  logic signed [VALUE_WIDTH-1:0] s1_value;
  item_ctl_t                     s1_ctl;

  logic                          wr_valid;
  logic [ADDR_W-1:0]             wr_addr;
  logic signed [SUM_W-1:0]       wr_sum;

  logic signed [SUM_W-1:0]       base;
  logic signed [SUM_W-1:0]       value_ext;
  logic signed [SUM_W-1:0]       sum;

  always_ff @(posedge clk) begin
    if (req_valid) begin
      rd_data <= mem[req_addr];
    end
    if (s1_valid) begin
      mem[s1_addr] <= sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      wr_valid <= 1'b0;
    end else begin
      s1_valid <= req_valid;
      wr_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid) begin
      s1_addr  <= req_addr;
      s1_value <= req_value;
      s1_ctl   <= req_ctl;
    end
    wr_addr <= s1_addr;
    wr_sum  <= sum;
  end

  // forward the write that landed in the same cycle as this word's read
  always_comb begin
    value_ext = SUM_W'(s1_value);
    base      = (wr_valid && wr_addr == s1_addr) ? wr_sum : rd_data;
    sum       = s1_ctl.first ? value_ext : base + value_ext;
  end

  assign res_valid = s1_valid & s1_ctl.emit;
  assign res_value = sum[VALUE_WIDTH+2:3];
  assign res_last  = s1_ctl.last_cell;

endmodule

// File: src/grid_restriction_2x2x2_mean.sv
// ----------------------------------------------------------------------------
// grid_restriction_2x2x2_mean
// Cell-centered 2x2x2 restriction of a streamed fine grid to coarse means.
// ----------------------------------------------------------------------------
// Fine interior cells enter in raster order (x fastest, then y, then z) and
// each is folded into the accumulator of its coarse cell, held in one memory
// of (MAX_FINE_WIDTH/2)*(MAX_FINE_HEIGHT/2) entries that covers one coarse
// x-y plane. Every word costs one read-modify-write of that memory: read at
// acceptance, add and write back in the next cycle, with the last write
// forwarded when the next word hits the same entry. Throughput is one word
// per cycle while in_stall is low; a coarse result, complete with its eighth
// child, leaves through a two-word output queue. The coarse value is
// floor(sum/8) and last_of_volume marks the final coarse cell. Extents have
// bit 0 ignored and are clamped to 2 and to the MAX_FINE_* parameters.
// ----------------------------------------------------------------------------
module grid_restriction_2x2x2_mean
  import grm_pkg::*;
#(
  parameter int MAX_FINE_WIDTH  = 128,
  parameter int MAX_FINE_HEIGHT = 128,
  parameter int MAX_FINE_DEPTH  = 128,
  parameter int VALUE_WIDTH     = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wen,
  input  logic [CFG_INDEX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [VALUE_WIDTH-1:0] fine_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [VALUE_WIDTH-1:0] coarse_value,
  output logic                          last_of_volume
);

  localparam int ACC_COLS = MAX_FINE_WIDTH / 2;
  localparam int ACC_ROWS = MAX_FINE_HEIGHT / 2;
  localparam int DEPTH    = ACC_COLS * ACC_ROWS;
  localparam int ADDR_W   = $clog2(DEPTH);

  localparam int PX_W = $clog2(MAX_FINE_WIDTH);
  localparam int PY_W = $clog2(MAX_FINE_HEIGHT);
  localparam int PZ_W = $clog2(MAX_FINE_DEPTH);
  localparam int EX_W = $clog2(MAX_FINE_WIDTH + 1);
  localparam int EY_W = $clog2(MAX_FINE_HEIGHT + 1);
  localparam int EZ_W = $clog2(MAX_FINE_DEPTH + 1);
  localparam int MX   = MAX_FINE_WIDTH - MAX_FINE_WIDTH % 2;
  localparam int MY   = MAX_FINE_HEIGHT - MAX_FINE_HEIGHT % 2;
  localparam int MZ   = MAX_FINE_DEPTH - MAX_FINE_DEPTH % 2;

  logic [CFG_DATA_W-1:0] fine_width;
  logic [CFG_DATA_W-1:0] fine_height;
  logic [CFG_DATA_W-1:0] fine_depth;

  logic [PX_W-1:0] x_position;
  logic [PY_W-1:0] y_position;
  logic [PZ_W-1:0] z_position;

  logic [EX_W-1:0] ext_x;
  logic [EY_W-1:0] ext_y;
  logic [EZ_W-1:0] ext_z;
  logic [CFG_DATA_W-1:0] even_x;
  logic [CFG_DATA_W-1:0] even_y;
  logic [CFG_DATA_W-1:0] even_z;

  logic [EX_W-1:0] x_inc;
  logic [EY_W-1:0] y_inc;
  logic [EZ_W-1:0] z_inc;

  logic              accept;
  logic [ADDR_W-1:0] addr;
  item_ctl_t         ctl;

  logic                          res_valid;
  logic signed [VALUE_WIDTH-1:0] res_value;
  logic                          res_last;

  logic signed [VALUE_WIDTH-1:0] q_value [2];
  logic                          q_last  [2];
  logic                          rd_ptr;
  logic                          wr_ptr;
  logic [1:0]                    count;
  logic                          pop;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      fine_width  <= EXTENT_RESET;
      fine_height <= EXTENT_RESET;
      fine_depth  <= EXTENT_RESET;
    end else if (cfg_wen) begin
      case (cfg_index)
        CFG_FINE_WIDTH:  fine_width  <= cfg_data;
        CFG_FINE_HEIGHT: fine_height <= cfg_data;
        CFG_FINE_DEPTH:  fine_depth  <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamp extents
  always_comb begin
    even_x = {fine_width[CFG_DATA_W-1:1], 1'b0};
    even_y = {fine_height[CFG_DATA_W-1:1], 1'b0};
    even_z = {fine_depth[CFG_DATA_W-1:1], 1'b0};

    if (even_x < EXTENT_MIN)   ext_x = EX_W'(EXTENT_MIN);
    else if (int'(even_x) > MX) ext_x = EX_W'(MX);
    else                        ext_x = EX_W'(even_x);

    if (even_y < EXTENT_MIN)   ext_y = EY_W'(EXTENT_MIN);
    else if (int'(even_y) > MY) ext_y = EY_W'(MY);
    else                        ext_y = EY_W'(even_y);

    if (even_z < EXTENT_MIN)   ext_z = EZ_W'(EXTENT_MIN);
    else if (int'(even_z) > MZ) ext_z = EZ_W'(MZ);
    else                        ext_z = EZ_W'(even_z);
  end

  assign accept = in_valid & ~in_stall;

  always_comb begin
    x_inc = EX_W'(x_position) + EX_W'(1);
    y_inc = EY_W'(y_position) + EY_W'(1);
    z_inc = EZ_W'(z_position) + EZ_W'(1);

    ctl.first     = ~(x_position[0] | y_position[0] | z_position[0]);
    ctl.emit      = x_position[0] & y_position[0] & z_position[0];
    ctl.last_cell = (x_inc == ext_x) && (y_inc == ext_y) && (z_inc == ext_z);

    addr = ADDR_W'(ADDR_W'(y_position[PY_W-1:1]) * ADDR_W'(ACC_COLS)
                   + ADDR_W'(x_position[PX_W-1:1]));
  end

  // advance raster position
  always_ff @(posedge clk) begin
    if (rst) begin
      x_position <= '0;
      y_position <= '0;
      z_position <= '0;
    end else if (accept) begin
      if (x_inc >= ext_x) begin
        x_position <= '0;
        if (y_inc >= ext_y) begin
          y_position <= '0;
          if (z_inc >= ext_z) begin
            z_position <= '0;
          end else begin
            z_position <= z_inc[PZ_W-1:0];
          end
        end else begin
          y_position <= y_inc[PY_W-1:0];
        end
      end else begin
        x_position <= x_inc[PX_W-1:0];
      end
    end
  end

  grm_acc #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .DEPTH       (DEPTH),
    .ADDR_W      (ADDR_W)
  ) u_acc (
    .clk       (clk),
    .rst       (rst),
    .req_valid (accept),
    .req_addr  (addr),
    .req_value (fine_value),
    .req_ctl   (ctl),
    .res_valid (res_valid),
    .res_value (res_value),
    .res_last  (res_last)
  );

  // output queue
  assign out_valid      = (count != 2'd0);
  assign coarse_value   = q_value[rd_ptr];
  assign last_of_volume = q_last[rd_ptr];
  assign pop            = out_valid & ~out_stall;
  assign in_stall       = (3'(count) + 3'(res_valid)) >= 3'd2;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (res_valid) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (res_valid && !pop) begin
        count <= count + 2'd1;
      end else if (!res_valid && pop) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      q_value[wr_ptr] <= res_value;
      q_last[wr_ptr]  <= res_last;
    end
  end

endmodule
